FILE: src/iol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and constants for the indexed ordered list.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int REQ_W   = 3;
  localparam int COUNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND      = 3'd0,
    REQ_PREPEND     = 3'd1,
    REQ_REMOVE_LAST = 3'd2,
    REQ_REMOVE_HEAD = 3'd3,
    REQ_READ        = 3'd4,
    REQ_OVERWRITE   = 3'd5,
    REQ_INSERT      = 3'd6
  } req_code_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;   // capture the accepted request
    logic exec;    // apply the request to the cells and count
    logic load;    // load the result register
  } iol_cmd_t;

endpackage

`default_nettype wire

FILE: src/iol_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_if
// Request and result channels of the indexed ordered list.
// ----------------------------------------------------------------------------
interface iol_req_if
  import iol_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [POS_W-1:0]  position;
  logic signed [WORD_W-1:0] data_word;

  modport source (output valid, output req_type, output position, output data_word,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_word,
                  output ready);
endinterface

interface iol_res_if
  import iol_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] read_word;
  logic [COUNT_W-1:0]       count;
  logic signed [WORD_W-1:0] head_word;
  logic signed [WORD_W-1:0] tail_word;
  logic                     is_empty;

  modport source (output valid, output ok, output read_word, output count,
                  output head_word, output tail_word, output is_empty, input ready);
  modport sink   (input valid, input ok, input read_word, input count,
                  input head_word, input tail_word, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: src/indexed_ordered_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Bounded ordered list of signed words with indexed access.
// ----------------------------------------------------------------------------
// A request goes from acceptance to a loaded result in order: a step that
// captures it, a step in which every entry cell shifts, loads or holds in
// parallel, and a step in which the single shared read multiplexer fetches the
// tail word. A new request is taken while the previous result still waits on
// the output; a result that is not taken holds the sequencer in its last
// step. The list is empty after reset and needs no clearing pass; entries
// past the count are never read.
module indexed_ordered_list
  import iol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  iol_req_if.sink   req,
  iol_res_if.source res
);

  iol_cmd_t cmd;

  iol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd)
  );

  iol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (req.req_type),
    .position  (req.position),
    .data_word (req.data_word),
    .ok        (res.ok),
    .read_word (res.read_word),
    .count     (res.count),
    .head_word (res.head_word),
    .tail_word (res.tail_word),
    .is_empty  (res.is_empty)
  );

endmodule

`default_nettype wire

FILE: src/iol_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_ctrl
// Request sequencer: accept, execute, then hand the result to the output.
// ----------------------------------------------------------------------------
module iol_ctrl
  import iol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      res_valid,
  input  wire logic res_ready,
  output iol_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t state;
  logic   load_ok;

  // result register is free when empty or being drained this cycle
  assign load_ok   = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.latch = (state == ST_IDLE) && req_valid;
    cmd.exec  = (state == ST_EXEC);
    cmd.load  = (state == ST_FINISH) && load_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (load_ok) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.latch, cmd.exec, cmd.load}) <= 1)
    else $error("more than one datapath command at once");

  a_exec_follows_latch: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.exec)
    else $error("accepted request not executed");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!res_valid || res_ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: src/iol_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_dp
// Entry cells, count and result register of the indexed ordered list.
// ----------------------------------------------------------------------------
module iol_dp
  import iol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire iol_cmd_t                 cmd,
  input  wire logic [REQ_W-1:0]         req_type,
  input  wire logic signed [POS_W-1:0]  position,
  input  wire logic signed [WORD_W-1:0] data_word,
  output logic                          ok,
  output logic signed [WORD_W-1:0]      read_word,
  output logic [COUNT_W-1:0]            count,
  output logic signed [WORD_W-1:0]      head_word,
  output logic signed [WORD_W-1:0]      tail_word,
  output logic                          is_empty
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

  // captured request
  logic [REQ_W-1:0]  req_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;

  logic [WORD_W-1:0] store [CAPACITY];
  logic [WORD_W-1:0] below [CAPACITY];
  logic [WORD_W-1:0] above [CAPACITY];
  logic [CNT_W-1:0]  entries;

  logic              ok_r;
  logic [WORD_W-1:0] rd_r;

  logic [CMP_W-1:0]  pos_u;
  logic [CMP_W-1:0]  cnt_c;
  logic              room;
  logic              nonempty;
  logic              in_range;
  logic              in_gap;
  logic              do_put;
  logic              do_pop_head;
  logic              do_pop_last;
  logic              do_write;
  logic              do_read;
  logic              exec_ok;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  ins_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_sel;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= req_type;
      pos_r  <= position;
      word_r <= data_word;
    end
  end

  assign pos_u    = CMP_W'(pos_r[POS_W-2:0]);
  assign cnt_c    = CMP_W'(entries);
  assign room     = entries < CNT_W'(CAPACITY);
  assign nonempty = entries != '0;
  assign in_range = !pos_r[POS_W-1] && (pos_u < cnt_c);
  assign in_gap   = !pos_r[POS_W-1] && (pos_u <= cnt_c);
  assign pos_idx  = pos_u[IDX_W-1:0];
  assign tail_idx = IDX_W'(entries - CNT_W'(1));

  always_comb begin
    do_put      = 1'b0;
    do_pop_head = 1'b0;
    do_pop_last = 1'b0;
    do_write    = 1'b0;
    do_read     = 1'b0;
    ins_idx     = pos_idx;
    case (req_r)
      REQ_APPEND: begin
        do_put  = room;
        ins_idx = IDX_W'(entries);
      end
      REQ_PREPEND: begin
        do_put  = room;
        ins_idx = '0;
      end
      REQ_REMOVE_LAST: do_pop_last = nonempty;
      REQ_REMOVE_HEAD: do_pop_head = nonempty;
      REQ_READ:        do_read     = in_range;
      REQ_OVERWRITE:   do_write    = in_range;
      REQ_INSERT:      do_put      = in_gap && room;
      default: begin
        do_put = 1'b0;
      end
    endcase
  end

  assign exec_ok = do_put || do_pop_head || do_pop_last || do_write || do_read;

  // neighbor taps of each cell for the two shift directions
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g > 0) begin : g_lo
      assign below[g] = store[g-1];
    end else begin : g_lo0
      assign below[g] = '0;
    end
    if (g < CAPACITY - 1) begin : g_hi
      assign above[g] = store[g+1];
    end else begin : g_hi0
      assign above[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_put) begin
          if (ins_idx == IDX_W'(i)) begin
            store[i] <= word_r;
          end else if (ins_idx < IDX_W'(i)) begin
            store[i] <= below[i];
          end
        end else if (do_pop_head) begin
          store[i] <= above[i];
        end else if (do_write && (pos_idx == IDX_W'(i))) begin
          store[i] <= word_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (cmd.exec) begin
      if (do_put) begin
        entries <= entries + CNT_W'(1);
      end else if (do_pop_head || do_pop_last) begin
        entries <= entries - CNT_W'(1);
      end
    end
  end

  // one shared read port: indexed read while executing, tail afterwards
  assign rd_addr = cmd.exec ? pos_idx : tail_idx;
  assign rd_sel  = store[rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r <= exec_ok;
      rd_r <= do_read ? rd_sel : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok        <= ok_r;
      read_word <= rd_r;
      count     <= COUNT_W'(entries);
      head_word <= nonempty ? store[0] : '0;
      tail_word <= nonempty ? rd_sel : '0;
      is_empty  <= !nonempty;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(entries))
    else $error("entry count changed outside execution");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !exec_ok) |=> ($stable(entries) && !ok_r && rd_r == '0))
    else $error("rejected request changed state or result");

endmodule

`default_nettype wire

FILE: verif/tb_indexed_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_ordered_list
// Self-checking bench for the indexed ordered list. A queue of requests,
// directed corner cases first and then random grow/shrink waves, is driven
// through the request channel. A local list model predicts every result,
// and each result taken from the result channel is checked field by field
// in order. Both channels idle at random. One long receiver hold-off backs
// the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_indexed_ordered_list;
  import iol_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int NUM_RANDOM      = 780;
  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AT     = 500;
  localparam int CALM_FIRST      = 250;
  localparam int CALM_LAST       = 400;
  localparam int IDLE_PCT        = 22;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [POS_W-1:0]  position;
    logic signed [WORD_W-1:0] data_word;
  } list_req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] read_word;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] head_word;
    logic signed [WORD_W-1:0] tail_word;
    logic                     is_empty;
  } list_res_t;

  logic clk = 1'b0;
  logic rst;

  iol_req_if req_ch ();
  iol_res_if res_ch ();

  indexed_ordered_list #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the list contents
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int unsigned              list_len;

  list_req_t pending_reqs[$];
  list_res_t expected_results[$];

  int unsigned gen_len;        // shadow count used while building stimulus
  int unsigned reqs_accepted;
  int unsigned results_seen;
  int unsigned rejected_reqs;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned hold_off_left;
  logic        hold_off_done;
  logic        calm_stretch;

  function automatic void put_word(int unsigned slot, logic signed [WORD_W-1:0] word);
    for (int unsigned i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
    list_words[slot] = word;
    list_len++;
  endfunction

  function automatic list_res_t apply_list_request(list_req_t r);
    list_res_t   res;
    logic        room;
    logic        neg;
    int unsigned idx;
    res  = '0;
    room = (list_len < CAPACITY);
    neg  = r.position[POS_W-1];
    idx  = 32'(r.position[POS_W-2:0]);
    case (r.req_type)
      REQ_APPEND: if (room) begin
        put_word(list_len, r.data_word);
        res.ok = 1'b1;
      end
      REQ_PREPEND: if (room) begin
        put_word(0, r.data_word);
        res.ok = 1'b1;
      end
      REQ_REMOVE_LAST: if (list_len > 0) begin
        list_len--;
        res.ok = 1'b1;
      end
      REQ_REMOVE_HEAD: if (list_len > 0) begin
        for (int unsigned i = 1; i < list_len; i++) list_words[i-1] = list_words[i];
        list_len--;
        res.ok = 1'b1;
      end
      REQ_READ: if (!neg && idx < list_len) begin
        res.read_word = list_words[idx];
        res.ok        = 1'b1;
      end
      REQ_OVERWRITE: if (!neg && idx < list_len) begin
        list_words[idx] = r.data_word;
        res.ok          = 1'b1;
      end
      REQ_INSERT: if (!neg && idx <= list_len && room) begin
        put_word(idx, r.data_word);
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count     = list_len[COUNT_W-1:0];
    res.head_word = (list_len > 0) ? list_words[0] : '0;
    res.tail_word = (list_len > 0) ? list_words[list_len-1] : '0;
    res.is_empty  = (list_len == 0);
    if (!res.ok) rejected_reqs++;
    if (list_len == CAPACITY) full_hits++;
    if (list_len == 0) empty_hits++;
    return res;
  endfunction

  function automatic void queue_req(logic [REQ_W-1:0] t, logic signed [POS_W-1:0] p,
                                    logic signed [WORD_W-1:0] w);
    logic        neg;
    int unsigned idx;
    neg = p[POS_W-1];
    idx = 32'(p[POS_W-2:0]);
    pending_reqs.push_back('{t, p, w});
    case (t)
      REQ_APPEND, REQ_PREPEND: if (gen_len < CAPACITY) gen_len++;
      REQ_REMOVE_LAST, REQ_REMOVE_HEAD: if (gen_len > 0) gen_len--;
      REQ_INSERT: if (!neg && idx <= gen_len && gen_len < CAPACITY) gen_len++;
      default: ;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position(logic for_insert);
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(99);
    top = for_insert ? gen_len : ((gen_len > 0) ? gen_len - 1 : 0);
    if (r < 80) return POS_W'($urandom_range(top, 0));
    if (r < 88) return POS_W'(top + 1);
    if (r < 94) return POS_W'(-1);
    return POS_W'($urandom_range(255));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(39))
      0:       return '0;
      1:       return -1;
      2:       return 32'sh7FFF_FFFF;
      3:       return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_directed();
    queue_req(REQ_REMOVE_LAST, 0, 0);          // removals from an empty list
    queue_req(REQ_REMOVE_HEAD, 0, 0);
    queue_req(REQ_READ, 0, 0);
    queue_req(REQ_OVERWRITE, 0, 32'sh1234_5678);
    queue_req(REQ_INSERT, 1, 32'sh1111_1111);   // past count on empty
    queue_req(REQ_INSERT, 0, 32'sh7FFF_FFFF);
    queue_req(REQ_APPEND, 0, 32'sh8000_0000);
    queue_req(REQ_PREPEND, 0, 32'sh0000_0001);
    queue_req(REQ_INSERT, 3, -1);               // insert at count acts as append
    queue_req(REQ_INSERT, 2, 32'sh5A5A_5A5A);
    queue_req(REQ_READ, -1, 0);
    queue_req(REQ_READ, -128, 0);
    queue_req(REQ_READ, 127, 0);
    queue_req(REQ_READ, 0, 0);
    queue_req(REQ_READ, 4, 0);
    queue_req(REQ_READ, 5, 0);
    queue_req(REQ_OVERWRITE, 4, 0);
    queue_req(REQ_OVERWRITE, 0, -1);
    queue_req(REQ_OVERWRITE, 5, 32'sh2222_2222);
    queue_req(REQ_INSERT, 6, 32'sh3333_3333);
    queue_req(REQ_INSERT, -128, 32'sh4444_4444);
    queue_req(REQ_UNUSED, 0, 32'sh5555_5555);
    queue_req(REQ_REMOVE_HEAD, 0, 0);
    queue_req(REQ_REMOVE_LAST, 0, 0);
  endtask

  // Random part in grow and shrink waves so that full and empty are both
  // reached often; a small share of requests is raw noise.
  task automatic build_random();
    logic        grow;
    int unsigned r;
    grow = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (gen_len == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      if (gen_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
      r = $urandom_range(99);
      if (!grow) r = (r < 16) ? r * 4 : r;
      if (r >= 95) queue_req(REQ_W'($urandom_range(7)), POS_W'($urandom_range(255)), $urandom);
      else if (!grow && r < 64) begin
        if (r < 40) queue_req(REQ_REMOVE_LAST, pick_position(1'b0), pick_word());
        else queue_req(REQ_REMOVE_HEAD, pick_position(1'b0), pick_word());
      end else if (r < 25) queue_req(REQ_APPEND, pick_position(1'b0), pick_word());
      else if (r < 40) queue_req(REQ_PREPEND, pick_position(1'b0), pick_word());
      else if (r < 62) queue_req(REQ_INSERT, pick_position(1'b1), pick_word());
      else if (r < 70) queue_req(REQ_REMOVE_LAST, pick_position(1'b0), pick_word());
      else if (r < 76) queue_req(REQ_REMOVE_HEAD, pick_position(1'b0), pick_word());
      else if (r < 86) queue_req(REQ_READ, pick_position(1'b0), pick_word());
      else queue_req(REQ_OVERWRITE, pick_position(1'b0), pick_word());
    end
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : req_driver
    list_req_t item;
    logic      offer;
    if (rst) begin
      req_ch.valid  <= 1'b0;
      reqs_accepted <= 0;
      calm_stretch  <= 1'b0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_list_request(pending_reqs.pop_front()));
        reqs_accepted <= reqs_accepted + 1;
        offer = 1'b0;
      end
      calm_stretch <= (reqs_accepted >= CALM_FIRST && reqs_accepted < CALM_LAST);
      if (!offer && pending_reqs.size() > 0 &&
          (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
        item = pending_reqs[0];
        req_ch.req_type  <= item.req_type;
        req_ch.position  <= item.position;
        req_ch.data_word <= item.data_word;
        offer = 1'b1;
      end
      req_ch.valid <= offer;
    end
  end

  always @(posedge clk) begin : res_monitor
    list_res_t want;
    if (rst) begin
      res_ch.ready  <= 1'b0;
      results_seen  <= 0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %h",
                   $time, {res_ch.ok, res_ch.read_word, res_ch.count});
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", WORD_W'(want.ok), WORD_W'(res_ch.ok));
          check_field("read_word", want.read_word, res_ch.read_word);
          check_field("count", WORD_W'(want.count), WORD_W'(res_ch.count));
          check_field("head_word", want.head_word, res_ch.head_word);
          check_field("tail_word", want.tail_word, res_ch.tail_word);
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(res_ch.is_empty));
        end
      end
      // one long hold-off lets the block fill and back-pressure its input
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        res_ch.ready  <= 1'b0;
      end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
        hold_off_left <= HOLD_OFF_CYCLES;
        hold_off_done <= 1'b1;
        res_ch.ready  <= 1'b0;
      end else begin
        res_ch.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_APPEND;
    req_ch.position  = '0;
    req_ch.data_word = '0;
    res_ch.ready     = 1'b0;
    stall_cycles     = 0;
    list_len         = 0;
    gen_len          = 0;
    rejected_reqs    = 0;
    full_hits        = 0;
    empty_hits       = 0;
    mismatches       = 0;
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while ((pending_reqs.size() > 0 || expected_results.size() > 0) &&
           stall_cycles < STALL_LIMIT)
      @(posedge clk);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_results.size());
      $display("CHECK FAILED");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("Ran %0d requests, checked %0d results, %0d of them rejected.",
               reqs_accepted, results_seen, rejected_reqs);
      $display("List was left full after %0d requests and empty after %0d.",
               full_hits, empty_hits);
      if (mismatches == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
